// File: rtl/core/keyframe_sampler_interpolator_macros.svh
// Assertion macros for the keyframe sampler.
// Included by the top level; has no other dependencies.
`ifndef KEYFRAME_SAMPLER_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_SAMPLER_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define KSI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyframe sampler assertion failed");
`define KSI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyframe sampler assertion failed");
`else
`define KSI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define KSI_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/ksi_pkg.sv
// Shared types and constants of the keyframe sampler.
// No dependencies.
package ksi_pkg;
   localparam int KEY_DEPTH = 64;
   localparam int VAL_DEPTH = 192;
   localparam int KA_W = $clog2(KEY_DEPTH);
   localparam int VA_W = $clog2(VAL_DEPTH);
   localparam int QDEPTH = 2;
   localparam int QC_W = $clog2(QDEPTH + 1);

   localparam logic [1:0] MODE_KEY  = 2'd0;
   localparam logic [1:0] MODE_VAL  = 2'd1;
   localparam logic [1:0] MODE_EVAL = 2'd2;

   localparam logic [1:0] IM_LINEAR = 2'd0;
   localparam logic [1:0] IM_STEP   = 2'd1;
   localparam logic [1:0] IM_CUBIC  = 2'd2;

   localparam logic [1:0] STAT_INTERP = 2'd0;
   localparam logic [1:0] STAT_LOW    = 2'd1;
   localparam logic [1:0] STAT_HIGH   = 2'd2;
   localparam logic [1:0] STAT_EMPTY  = 2'd3;

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_KEYS = 2'd1;
   localparam logic [1:0] REG_VALS = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         entry_index;
      logic signed [31:0] time_value;
      logic signed [31:0] val_x;
      logic signed [31:0] val_y;
      logic signed [31:0] val_z;
      logic signed [31:0] val_w;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_w;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [1:0] {OP_KEY, OP_VAL, OP_EVAL} op_type;

   typedef struct packed {
      op_type             op;
      logic [7:0]         slot;
      logic signed [31:0] t;
      logic [127:0]       val;
   } cmd_type;

   typedef struct packed {
      logic [1:0] interp_mode;
      logic [6:0] key_count;
      logic [7:0] value_count;
   } cfg_type;

   typedef struct packed {
      logic [QC_W-1:0] count;
   } fst_type;
endpackage

// File: rtl/core/ksi_front.sv
// Front end of the keyframe sampler: accepts words, classifies them and queues the valid ones.
// Depends on ksi_pkg.
module ksi_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ksi_pkg::req_type req_data,
   output logic             cmd_valid,
   output ksi_pkg::cmd_type cmd,
   input  logic             cmd_pop,
   output ksi_pkg::fst_type fst
);
   import ksi_pkg::*;

   localparam int QP_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   cmd_type         q_ff [QDEPTH];
   logic [QP_W-1:0] rd_ptr_ff;
   logic [QP_W-1:0] wr_ptr_ff;
   logic [QC_W-1:0] count_ff;
   logic            keep;
   logic            push;
   cmd_type         cls;

   always_comb begin
      cls.slot = req_data.entry_index;
      cls.t = req_data.time_value;
      cls.val = {req_data.val_x, req_data.val_y, req_data.val_z, req_data.val_w};
      cls.op = OP_EVAL;
      keep = 1'b0;
      case (req_data.mode)
         MODE_KEY: begin
            cls.op = OP_KEY;
            keep = {1'b0, req_data.entry_index} < 9'(KEY_DEPTH);
         end
         MODE_VAL: begin
            cls.op = OP_VAL;
            keep = {1'b0, req_data.entry_index} < 9'(VAL_DEPTH);
         end
         MODE_EVAL: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = count_ff != QC_W'(QDEPTH);
   assign push = req_valid && req_ready && keep;
   assign cmd_valid = count_ff != '0;
   assign cmd = q_ff[rd_ptr_ff];
   assign fst.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            q_ff[wr_ptr_ff] <= cls;
            wr_ptr_ff <= (wr_ptr_ff == QP_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QP_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QC_W'(push) - QC_W'(cmd_pop);
      end
   end
endmodule

// File: rtl/core/ksi_back.sv
// Back end of the keyframe sampler: key and value tables, search, divider and interpolation.
// Depends on ksi_pkg.
module ksi_back (
   input  logic             clock,
   input  logic             reset,
   input  ksi_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  ksi_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ksi_pkg::rsp_type rsp_data
);
   import ksi_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_RK0, S_CK0, S_RKL, S_CKL, S_SRCH, S_SCMP, S_RT0, S_RT1, S_DT, S_DIV,
      S_DISP, S_FETCH, S_LMUL, S_LACC, S_CF2, S_CF3, S_CH, S_CM0, S_CM1, S_CS1, S_CS2,
      S_CS3, S_CFIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {K_HOLD, K_LIN, K_CUB} kind_type;

   function automatic logic signed [55:0] rnd16(input logic signed [71:0] x);
      logic signed [71:0] s;
      s = x + 72'sd32768;
      return s[71:16];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [55:0] x);
      if (x > 56'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -56'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] comp(input logic [127:0] v, input logic [1:0] c);
      return v[(2'd3 - c) * 32 +: 32];
   endfunction

   function automatic logic [7:0] vsel(input logic [7:0] i, input logic [7:0] vc);
      return (i < vc) ? i : vc - 8'd1;
   endfunction

   logic signed [31:0] key_times_mem [KEY_DEPTH];
   logic [127:0]       key_values_mem [VAL_DEPTH];

   state_type          state_ff;
   kind_type           kind_ff;
   logic signed [31:0] kt_q_ff;
   logic [127:0]       vq_ff;
   logic [VA_W-1:0]    vaddr_ff;
   logic [KA_W-1:0]    kt_ra;
   logic signed [31:0] t_ff;
   logic signed [31:0] t0_ff;
   logic [6:0]         kc_ff;
   logic [7:0]         vc_ff;
   logic [KA_W-1:0]    lo_ff;
   logic [KA_W-1:0]    hi_ff;
   logic [KA_W-1:0]    mid;
   logic [31:0]        dt_ff;
   logic [31:0]        rem_ff;
   logic [16:0]        f_ff;
   logic [16:0]        f2_ff;
   logic [16:0]        f3_ff;
   logic [4:0]         cnt_ff;
   logic [2:0]         nf_ff;
   logic [7:0]         fa_ff [4];
   logic [127:0]       ent_ff [4];
   logic signed [50:0] lprod_ff;
   logic signed [19:0] h00_ff;
   logic signed [19:0] h10_ff;
   logic signed [19:0] h01_ff;
   logic signed [19:0] h11_ff;
   logic signed [49:0] m0_ff;
   logic signed [49:0] m1_ff;
   logic signed [71:0] acc_ff;
   logic signed [31:0] res_ff [4];
   logic [1:0]         stat_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [6:0]         kc_in;
   logic [7:0]         vc_in;
   logic               cubic_ends;
   logic [1:0]         c;
   logic [2:0]         fc;
   logic signed [32:0] dtd;
   logic signed [32:0] nd;
   logic [32:0]        r2;
   logic [33:0]        fsq;
   logic [33:0]        fcu;
   logic signed [19:0] e2;
   logic signed [19:0] e3;
   logic signed [19:0] ef;
   logic signed [32:0] dlt;
   logic signed [64:0] tp;
   logic signed [55:0] lsum;
   logic signed [55:0] mr;
   logic [7:0]         i0;
   logic [7:0]         i1;

   always_comb begin
      kc_in = (cfg.key_count > 7'(KEY_DEPTH)) ? 7'(KEY_DEPTH) : cfg.key_count;
      vc_in = (cfg.value_count > 8'(VAL_DEPTH)) ? 8'(VAL_DEPTH) : cfg.value_count;
      cubic_ends = (cfg.interp_mode == IM_CUBIC) && (vc_ff >= 8'd3);
      mid = lo_ff + ((hi_ff - lo_ff) >> 1);
      c = cnt_ff[1:0];
      fc = cnt_ff[2:0] - 3'd2;
      dtd = {kt_q_ff[31], kt_q_ff} - {t0_ff[31], t0_ff};
      nd = {t_ff[31], t_ff} - {t0_ff[31], t0_ff};
      r2 = {rem_ff, 1'b0};
      fsq = 34'(f_ff) * 34'(f_ff);
      fcu = 34'(f2_ff) * 34'(f_ff);
      e2 = $signed({3'b000, f2_ff});
      e3 = $signed({3'b000, f3_ff});
      ef = $signed({3'b000, f_ff});
      dlt = {comp(ent_ff[1], c)[31], comp(ent_ff[1], c)}
            - {comp(ent_ff[0], c)[31], comp(ent_ff[0], c)};
      lsum = {{24{comp(ent_ff[0], c)[31]}}, comp(ent_ff[0], c)}
             + rnd16({{21{lprod_ff[50]}}, lprod_ff});
      if (state_ff == S_CM0) begin
         tp = comp(ent_ff[1], c) * $signed({1'b0, dt_ff});
      end else begin
         tp = comp(ent_ff[3], c) * $signed({1'b0, dt_ff});
      end
      mr = rnd16({{7{tp[64]}}, tp});
      i0 = {2'b00, lo_ff} * 8'd3;
      i1 = i0 + 8'd3;
      case (state_ff)
         S_RKL: kt_ra = KA_W'(kc_ff - 7'd1);
         S_SRCH: kt_ra = mid;
         S_RT0: kt_ra = lo_ff;
         S_RT1: kt_ra = lo_ff + 1'b1;
         default: kt_ra = '0;
      endcase
   end

   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.op == OP_KEY) begin
         key_times_mem[cmd.slot[KA_W-1:0]] <= cmd.t;
      end
      kt_q_ff <= key_times_mem[kt_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.op == OP_VAL) begin
         key_values_mem[cmd.slot[VA_W-1:0]] <= cmd.val;
      end
      vq_ff <= key_values_mem[vaddr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_pop && cmd.op == OP_EVAL) begin
                  t_ff <= cmd.t;
                  kc_ff <= kc_in;
                  vc_ff <= vc_in;
                  if (kc_in == '0 || vc_in == '0) begin
                     for (int k = 0; k < 4; k++) res_ff[k] <= '0;
                     stat_ff <= STAT_EMPTY;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_RK0;
                  end
               end
            end
            S_RK0: state_ff <= S_CK0;
            S_CK0: begin
               cnt_ff <= '0;
               if (t_ff <= kt_q_ff) begin
                  fa_ff[0] <= cubic_ends ? 8'd1 : 8'd0;
                  nf_ff <= 3'd1;
                  kind_ff <= K_HOLD;
                  stat_ff <= STAT_LOW;
                  state_ff <= S_FETCH;
               end else begin
                  state_ff <= S_RKL;
               end
            end
            S_RKL: state_ff <= S_CKL;
            S_CKL: begin
               if (t_ff >= kt_q_ff) begin
                  fa_ff[0] <= cubic_ends ? vc_ff - 8'd2 : vc_ff - 8'd1;
                  nf_ff <= 3'd1;
                  kind_ff <= K_HOLD;
                  stat_ff <= STAT_HIGH;
                  state_ff <= S_FETCH;
               end else begin
                  lo_ff <= '0;
                  hi_ff <= KA_W'(kc_ff - 7'd1);
                  state_ff <= S_SRCH;
               end
            end
            S_SRCH: begin
               if ({1'b0, lo_ff} + 1'b1 < {1'b0, hi_ff}) begin
                  state_ff <= S_SCMP;
               end else begin
                  state_ff <= S_RT0;
               end
            end
            S_SCMP: begin
               if (t_ff < kt_q_ff) begin
                  hi_ff <= mid;
               end else begin
                  lo_ff <= mid;
               end
               state_ff <= S_SRCH;
            end
            S_RT0: state_ff <= S_RT1;
            S_RT1: begin
               t0_ff <= kt_q_ff;
               state_ff <= S_DT;
            end
            S_DT: begin
               if (dtd < 33'sd1) begin
                  dt_ff <= 32'd1;
               end else begin
                  dt_ff <= dtd[31:0];
               end
               cnt_ff <= '0;
               f_ff <= '0;
               rem_ff <= nd[31:0];
               if (nd <= 33'sd0) begin
                  state_ff <= S_DISP;
               end else if ((dtd < 33'sd1) || (nd >= dtd)) begin
                  f_ff <= 17'd65536;
                  state_ff <= S_DISP;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (r2 >= {1'b0, dt_ff}) begin
                  rem_ff <= 32'(r2 - {1'b0, dt_ff});
                  f_ff <= {f_ff[15:0], 1'b1};
               end else begin
                  rem_ff <= r2[31:0];
                  f_ff <= {f_ff[15:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd15) begin
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               cnt_ff <= '0;
               stat_ff <= STAT_INTERP;
               kind_ff <= K_HOLD;
               nf_ff <= 3'd1;
               state_ff <= S_FETCH;
               case (cfg.interp_mode)
                  IM_LINEAR: begin
                     fa_ff[0] <= vsel({2'b00, lo_ff}, vc_ff);
                     fa_ff[1] <= vsel({2'b00, lo_ff} + 8'd1, vc_ff);
                     nf_ff <= 3'd2;
                     kind_ff <= K_LIN;
                  end
                  IM_STEP: begin
                     fa_ff[0] <= vsel({2'b00, lo_ff}, vc_ff);
                  end
                  IM_CUBIC: begin
                     if (i1 + 8'd1 >= vc_ff) begin
                        fa_ff[0] <= vsel(i0 + 8'd1, vc_ff);
                     end else begin
                        fa_ff[0] <= i0 + 8'd1;
                        fa_ff[1] <= i0 + 8'd2;
                        fa_ff[2] <= i1 + 8'd1;
                        fa_ff[3] <= i1;
                        nf_ff <= 3'd4;
                        kind_ff <= K_CUB;
                     end
                  end
                  default: begin
                     for (int k = 0; k < 4; k++) res_ff[k] <= '0;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_FETCH: begin
               if (cnt_ff[2:0] < nf_ff) begin
                  vaddr_ff <= VA_W'(fa_ff[c]);
               end
               if (cnt_ff[2:0] >= 3'd2) begin
                  ent_ff[fc[1:0]] <= vq_ff;
               end
               if (cnt_ff[2:0] == nf_ff + 3'd1) begin
                  cnt_ff <= '0;
                  case (kind_ff)
                     K_LIN: state_ff <= S_LMUL;
                     K_CUB: state_ff <= S_CF2;
                     default: begin
                        for (int k = 0; k < 4; k++) res_ff[k] <= comp(vq_ff, 2'(k));
                        state_ff <= S_OUT;
                     end
                  endcase
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            S_LMUL: begin
               lprod_ff <= dlt * $signed({1'b0, f_ff});
               state_ff <= S_LACC;
            end
            S_LACC: begin
               res_ff[c] <= sat32(lsum);
               cnt_ff <= cnt_ff + 5'd1;
               state_ff <= (c == 2'd3) ? S_OUT : S_LMUL;
            end
            S_CF2: begin
               f2_ff <= 17'((fsq + 34'd32768) >> 16);
               state_ff <= S_CF3;
            end
            S_CF3: begin
               f3_ff <= 17'((fcu + 34'd32768) >> 16);
               state_ff <= S_CH;
            end
            S_CH: begin
               h00_ff <= (e3 <<< 1) - ((e2 <<< 1) + e2) + 20'sd65536;
               h10_ff <= e3 - (e2 <<< 1) + ef;
               h01_ff <= ((e2 <<< 1) + e2) - (e3 <<< 1);
               h11_ff <= e3 - e2;
               state_ff <= S_CM0;
            end
            S_CM0: begin
               m0_ff <= mr[49:0];
               state_ff <= S_CM1;
            end
            S_CM1: begin
               m1_ff <= mr[49:0];
               acc_ff <= h00_ff * comp(ent_ff[0], c);
               state_ff <= S_CS1;
            end
            S_CS1: begin
               acc_ff <= acc_ff + h10_ff * m0_ff;
               state_ff <= S_CS2;
            end
            S_CS2: begin
               acc_ff <= acc_ff + h01_ff * comp(ent_ff[2], c);
               state_ff <= S_CS3;
            end
            S_CS3: begin
               acc_ff <= acc_ff + h11_ff * m1_ff;
               state_ff <= S_CFIN;
            end
            S_CFIN: begin
               res_ff[c] <= sat32(rnd16(acc_ff));
               cnt_ff <= cnt_ff + 5'd1;
               state_ff <= (c == 2'd3) ? S_OUT : S_CM0;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff <= {res_ff[0], res_ff[1], res_ff[2], res_ff[3], stat_ff};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/core/keyframe_sampler_interpolator.sv
// The back end works one word at a time: key search, a serial divider and, in cubic mode,
// a multiply-accumulate sequence per component set how long an evaluate word takes.
// The input queue holds two words, so the front keeps accepting while the back works
// until the queue is full.
// Reset clears control state and configuration; the tables are undefined until written.
`include "keyframe_sampler_interpolator_macros.svh"
module keyframe_sampler_interpolator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ksi_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ksi_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);
   import ksi_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   fst_type fst;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE: cfg_ff.interp_mode <= csr_wdata[1:0];
            REG_KEYS: cfg_ff.key_count <= csr_wdata[6:0];
            REG_VALS: cfg_ff.value_count <= csr_wdata;
            default: ;
         endcase
      end
   end

   ksi_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .fst(fst)
   );

   ksi_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd_valid(cmd_valid), .cmd(cmd),
      .cmd_pop(cmd_pop), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   `KSI_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && rsp_data.status == STAT_EMPTY, rsp_data.out_x == '0 && rsp_data.out_w == '0)
   `KSI_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, fst.count <= QC_W'(QDEPTH))
   `KSI_ASSERT_NXT(a_full_holds, clock, reset, fst.count == QC_W'(QDEPTH) && !cmd_pop, fst.count == QC_W'(QDEPTH))
endmodule
